>>> rtl/i2m_pkg.sv
// Package for the IP to MAC lookup table.
// Holds the request mode codes and the request token that travels the cell chain.
// No dependencies.
package i2m_pkg;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// request token handed from cell to cell
	typedef struct packed {
		logic             vld;
		logic             mode;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic             hit;
		logic             done;   // request resolved: hit, appended, or lookup reached an empty entry
		logic [MAC_W-1:0] found;
	} i2m_tok_t;

endpackage

>>> rtl/i2m_cell.sv
// One table entry of the IP to MAC lookup table, plus one chain stage.
// Compares the passing request, updates or fills its entry, and hands the token on.
// Depends on i2m_pkg.
module i2m_cell
	import i2m_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  i2m_tok_t tok_in,
	output i2m_tok_t tok_out
);

	logic             entry_vld_q;
	logic [IP_W-1:0]  entry_ip_q;
	logic [MAC_W-1:0] entry_mac_q;
	i2m_tok_t         tok_q;

	logic     live;
	logic     match;
	logic     append;
	i2m_tok_t tok_nxt;

	assign live   = tok_in.vld && !tok_in.done;
	assign match  = live && entry_vld_q && (entry_ip_q == tok_in.ip);
	// valid entries form a prefix, so the first empty cell reached is the append slot
	assign append = live && !entry_vld_q && (tok_in.mode == MODE_INSERT);

	always_comb begin
		tok_nxt = tok_in;
		if (match) begin
			tok_nxt.hit  = 1'b1;
			tok_nxt.done = 1'b1;
			if (tok_in.mode == MODE_LOOKUP) begin
				tok_nxt.found = entry_mac_q;
			end
		end
		if (live && !entry_vld_q) begin
			tok_nxt.done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= 1'b0;
			tok_q       <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (append) begin
				entry_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (append) begin
			entry_ip_q  <= tok_in.ip;
			entry_mac_q <= tok_in.mac;
		end else if (match && (tok_in.mode == MODE_INSERT)) begin
			entry_mac_q <= tok_in.mac;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> rtl/ip_to_mac_lookup_table.sv
// IP to MAC lookup table (ARP cache), top level.
// Chains TABLE_ENTRIES i2m_cell instances and registers the result. Depends on i2m_pkg.
//
// Each request (insert/update or lookup) walks the row of TABLE_ENTRIES cells, one cell per
// clock, and its result lands in an output register after that. One request is in flight at a
// time: out_valid rises once the request has left the last cell, and the next one is
// accepted the cycle after the result is taken, so the wait between requests is set by the
// length of the cell chain and by out_ready. Entries fill in order and are never freed; an
// insert of a new IP into a full table is dropped and reported by table_full.
// found_mac is the stored MAC on a lookup hit and zero otherwise.
module ip_to_mac_lookup_table
	import i2m_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             mode,
	input  logic [IP_W-1:0]  ip_addr,
	input  logic [MAC_W-1:0] mac_addr,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             hit,
	output logic [MAC_W-1:0] found_mac,
	output logic             table_full
);

	i2m_tok_t tok_chain [0:TABLE_ENTRIES];
	logic [TABLE_ENTRIES:0] chain_vld;

	logic             busy_q;
	logic             out_valid_q;
	logic             hit_q;
	logic [MAC_W-1:0] found_q;
	logic             full_q;

	logic     in_acc;
	logic     out_acc;
	i2m_tok_t tok_head;
	i2m_tok_t tok_last;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid_q && out_ready;

	always_comb begin
		tok_head.vld   = in_acc;
		tok_head.mode  = mode;
		tok_head.ip    = ip_addr;
		tok_head.mac   = mac_addr;
		tok_head.hit   = 1'b0;
		tok_head.done  = 1'b0;
		tok_head.found = '0;
	end

	assign tok_chain[0] = tok_head;

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		i2m_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_chain[g]),
			.tok_out (tok_chain[g+1])
		);
	end

	for (genvar v = 0; v <= TABLE_ENTRIES; v++) begin : g_vld
		assign chain_vld[v] = tok_chain[v].vld;
	end

	assign tok_last = tok_chain[TABLE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (out_acc) begin
				busy_q <= 1'b0;
			end
			if (tok_last.vld) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_last.vld) begin
			hit_q   <= tok_last.hit;
			found_q <= tok_last.found;
			// an insert still unresolved at the end of the chain found no free entry
			full_q  <= (tok_last.mode == MODE_INSERT) && !tok_last.done;
		end
	end

	assign in_ready   = !busy_q;
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign found_mac  = found_q;
	assign table_full = full_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_vld) <= 1)
		else $error("more than one request in the cell chain");

	// chain_vld[0] is the accept strobe itself; busy is registered from it
	a_result_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q || (chain_vld[TABLE_ENTRIES:1] != '0)) |-> busy_q)
		else $error("request in flight while block reports idle");

	a_no_accept_when_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready)
		else $error("input ready while a result waits");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && full_q))
		else $error("dropped insert reported as hit");

	a_found_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (found_q != '0)) |-> hit_q)
		else $error("nonzero MAC returned without a hit");

endmodule
